// ===== design/text_console_cursor_scroll_defines.svh =====
// Assertion macros shared by the checker of the text console.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define TCCS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define TCCS_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// ===== design/tccs_pkg.sv =====
// Shared types and constants of the text console.
// Used by the controller, the datapath, the top level and the testbench.
package tccs_pkg;

  // Request modes.
  typedef enum logic [1:0] {
    MODE_PUT   = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_READ  = 2'd2
  } mode_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_INIT,
    ST_INIT_WAIT,
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP
  } state_e;

  typedef logic [15:0] cell_t;
  typedef logic [7:0]  byte_t;
  typedef logic [6:0]  col_port_t;
  typedef logic [4:0]  row_port_t;
  typedef logic [10:0] index_port_t;

  localparam byte_t CHAR_NEWLINE   = 8'h0A;
  localparam byte_t CHAR_BACKSPACE = 8'h08;
  localparam cell_t BLANK_CELL     = 16'h0020;
  localparam byte_t ATTR_RESET     = 8'h07;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch_item;
    logic exec;
    logic sweep_start;
    logic sweep_copy;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sweep_done;
    logic item_sweep;
    logic item_copy;
    logic out_free;
  } sts_t;

endpackage

// ===== design/tccs_ctrl.sv =====
// Controller state machine of the text console.
// Depends on tccs_pkg; drives the datapath tccs_dp through cmd_t and reads sts_t.
module tccs_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  tccs_pkg::sts_t   sts_i,
  output tccs_pkg::cmd_t   cmd_o
);

  tccs_pkg::state_e state_q, state_d;
  logic             pending_q, pending_d;
  logic             can_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tccs_pkg::ST_INIT;
      pending_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pending_q <= pending_d;
    end
  end

  // A new request may enter once the previous result has left or leaves now.
  assign can_take = (state_q == tccs_pkg::ST_IDLE) && (!pending_q || sts_i.out_free);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tccs_pkg::ST_INIT: begin
        state_d = tccs_pkg::ST_INIT_WAIT;
      end
      tccs_pkg::ST_INIT_WAIT: begin
        if (sts_i.sweep_done) state_d = tccs_pkg::ST_IDLE;
      end
      tccs_pkg::ST_IDLE: begin
        if (can_take && in_valid_i) state_d = tccs_pkg::ST_EXEC;
      end
      tccs_pkg::ST_EXEC: begin
        state_d = sts_i.item_sweep ? tccs_pkg::ST_SWEEP : tccs_pkg::ST_IDLE;
      end
      tccs_pkg::ST_SWEEP: begin
        if (sts_i.sweep_done) state_d = tccs_pkg::ST_IDLE;
      end
      default: begin
        state_d = tccs_pkg::ST_INIT;
      end
    endcase
  end

  always_comb begin
    in_stall_o         = !can_take;
    cmd_o.latch_item   = can_take && in_valid_i;
    cmd_o.exec         = (state_q == tccs_pkg::ST_EXEC);
    cmd_o.sweep_start  = (state_q == tccs_pkg::ST_INIT) ||
                         ((state_q == tccs_pkg::ST_EXEC) && sts_i.item_sweep);
    cmd_o.sweep_copy   = (state_q == tccs_pkg::ST_EXEC) && sts_i.item_copy;
    cmd_o.out_load     = pending_q && sts_i.out_free;
    pending_d          = pending_q && !cmd_o.out_load;
    if (((state_q == tccs_pkg::ST_EXEC) && !sts_i.item_sweep) ||
        ((state_q == tccs_pkg::ST_SWEEP) && sts_i.sweep_done)) begin
      pending_d = 1'b1;
    end
  end

endmodule

// ===== design/tccs_dp.sv =====
// Datapath of the text console: cell memory, cursor, sweep engine, result register.
// Depends on tccs_pkg; commanded by tccs_ctrl.
module tccs_dp #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tccs_pkg::cmd_t        cmd_i,
  output tccs_pkg::sts_t        sts_o,
  input  logic [1:0]            mode_i,
  input  logic [7:0]            char_code_i,
  input  logic [10:0]           cell_index_i,
  input  logic [7:0]            attr_i,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output logic [15:0]           cell_value_o,
  output logic [6:0]            cursor_col_o,
  output logic [4:0]            cursor_row_o,
  output logic                  scrolled_o
);

  localparam int Cells     = COLUMNS * ROWS;
  localparam int CopyCells = (ROWS - 1) * COLUMNS;
  localparam int AW        = $clog2(Cells);
  localparam int CW        = $clog2(COLUMNS);
  localparam int RW        = $clog2(ROWS);
  localparam logic [AW-1:0] LastAddr = AW'(Cells - 1);
  localparam logic [AW-1:0] CopyEnd  = AW'(CopyCells);
  localparam logic [CW-1:0] LastCol  = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] LastRow  = RW'(ROWS - 1);

  tccs_pkg::cell_t cell_mem [Cells];
  tccs_pkg::cell_t rd_data_q;

  // Latched request.
  logic [1:0]      item_mode_q;
  tccs_pkg::byte_t item_code_q;
  logic            item_rd_ok_q;

  logic [CW-1:0]   col_q, col_d;
  logic [RW-1:0]   row_q, row_d;

  // Sweep engine: address counter and one stage that waits for read data.
  logic            busy_q, copy_q;
  logic [AW-1:0]   ptr_q;
  logic            cp_valid_q, cp_blank_q;
  logic [AW-1:0]   cp_addr_q;

  tccs_pkg::cell_t res_value_q;
  logic            res_scrolled_q;
  logic            out_valid_q;

  logic            rd_ok;
  logic [AW-1:0]   rd_addr, wr_addr, cur_addr;
  logic            wr_en, put_write, scroll;
  tccs_pkg::cell_t wr_data, res_value_d;

  assign rd_ok    = 32'(cell_index_i) < Cells;
  assign cur_addr = AW'(row_q * COLUMNS) + AW'(col_q);

  // Cursor movement and what the request needs from the sweep engine.
  always_comb begin
    col_d     = col_q;
    row_d     = row_q;
    scroll    = 1'b0;
    put_write = 1'b0;
    unique case (item_mode_q)
      tccs_pkg::MODE_PUT: begin
        if (item_code_q == tccs_pkg::CHAR_NEWLINE) begin
          col_d = '0;
          if (row_q == LastRow) scroll = 1'b1;
          else row_d = row_q + RW'(1);
        end else if (item_code_q == tccs_pkg::CHAR_BACKSPACE) begin
          if (col_q != '0) col_d = col_q - CW'(1);
        end else begin
          put_write = 1'b1;
          if (col_q == LastCol) begin
            col_d = '0;
            if (row_q == LastRow) scroll = 1'b1;
            else row_d = row_q + RW'(1);
          end else begin
            col_d = col_q + CW'(1);
          end
        end
      end
      tccs_pkg::MODE_CLEAR: begin
        col_d = '0;
        row_d = '0;
      end
      default: begin
      end
    endcase
  end

  assign sts_o.item_sweep = (item_mode_q == tccs_pkg::MODE_CLEAR) ||
                            ((item_mode_q == tccs_pkg::MODE_PUT) && scroll);
  assign sts_o.item_copy  = (item_mode_q == tccs_pkg::MODE_PUT);
  assign sts_o.sweep_done = cp_valid_q && (cp_addr_q == LastAddr);
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  assign res_value_d = ((item_mode_q == tccs_pkg::MODE_READ) && item_rd_ok_q) ?
                       rd_data_q : '0;

  // Memory port selection.
  always_comb begin
    if (busy_q) begin
      rd_addr = (copy_q && (ptr_q < CopyEnd)) ? ptr_q + AW'(COLUMNS) : '0;
    end else begin
      rd_addr = rd_ok ? AW'(cell_index_i) : '0;
    end
    wr_en   = cp_valid_q || (cmd_i.exec && put_write);
    wr_addr = cp_valid_q ? cp_addr_q : cur_addr;
    if (cp_valid_q) begin
      wr_data = cp_blank_q ? tccs_pkg::BLANK_CELL : rd_data_q;
    end else begin
      wr_data = {attr_i, item_code_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) cell_mem[wr_addr] <= wr_data;
    rd_data_q <= cell_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_item) begin
      item_mode_q  <= mode_i;
      item_code_q  <= char_code_i;
      item_rd_ok_q <= rd_ok;
    end
    if (cmd_i.exec) begin
      res_value_q    <= res_value_d;
      res_scrolled_q <= (item_mode_q == tccs_pkg::MODE_PUT) && scroll;
    end
    if (cmd_i.sweep_start) copy_q <= cmd_i.sweep_copy;
    cp_addr_q  <= ptr_q;
    cp_blank_q <= !copy_q || (ptr_q >= CopyEnd);
    if (cmd_i.out_load) begin
      cell_value_o <= res_value_q;
      cursor_col_o <= tccs_pkg::col_port_t'(col_q);
      cursor_row_o <= tccs_pkg::row_port_t'(row_q);
      scrolled_o   <= res_scrolled_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      busy_q      <= 1'b0;
      ptr_q       <= '0;
      cp_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.exec) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (cmd_i.sweep_start) begin
        busy_q <= 1'b1;
        ptr_q  <= '0;
      end else if (busy_q) begin
        ptr_q <= ptr_q + AW'(1);
        if (ptr_q == LastAddr) busy_q <= 1'b0;
      end
      cp_valid_q <= busy_q;
      if (cmd_i.out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== design/text_console_cursor_scroll.sv =====
// Text console with its own cell memory; top level joining controller and datapath.
// Depends on tccs_pkg, tccs_ctrl and tccs_dp.
//
// Usage. Requests enter on the input channel (in_valid_i, in_stall_o) and carry
// mode_i, char_code_i and cell_index_i. Every request gives exactly one result on
// the output channel (out_valid_o, out_stall_i): the read cell value, the cursor
// position after the request and a flag that tells whether the screen scrolled.
// A request is taken at a clock edge where valid is high and stall is low.
// The attribute byte is written through cfg_we_i and cfg_data_i at any edge.
// Execution. A put that does not scroll, a read, or an unused mode passes through
// the execute state, the result register and the output register; no new request
// is taken while one is executing. A put that scrolls and a clear walk the whole
// cell memory through its single write port, one cell per cycle.
// Reset. After rst_ni is released the block blanks all COLUMNS*ROWS cells in a
// clearing pass; in_stall_o stays high meanwhile.
// Stall. The result sits in an output register; while the receiver stalls, the
// block still takes one more request and holds its result until the register is
// free, then stalls the input side.
module text_console_cursor_scroll #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  char_code_i,
  input  logic [10:0] cell_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] cell_value_o,
  output logic [6:0]  cursor_col_o,
  output logic [4:0]  cursor_row_o,
  output logic        scrolled_o
);

  // The attribute register is placed in the upper byte of every cell written by a put.
  tccs_pkg::byte_t attr_q;
  tccs_pkg::cmd_t  cmd;
  tccs_pkg::sts_t  sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= tccs_pkg::ATTR_RESET;
    end else if (cfg_we_i) begin
      attr_q <= cfg_data_i;
    end
  end

  // The controller sequences each request; the datapath owns the cells, cursor and results.
  tccs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tccs_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .mode_i       (mode_i),
    .char_code_i  (char_code_i),
    .cell_index_i (cell_index_i),
    .attr_i       (attr_q),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .cell_value_o (cell_value_o),
    .cursor_col_o (cursor_col_o),
    .cursor_row_o (cursor_row_o),
    .scrolled_o   (scrolled_o)
  );

endmodule

// ===== design/tccs_checker.sv =====
// Port-level checker of the text console and its bind to the top level.
// Depends on text_console_cursor_scroll_defines.svh.
`include "text_console_cursor_scroll_defines.svh"

module tccs_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_i,
  input logic        out_valid_i,
  input logic        out_stall_i,
  input logic [15:0] cell_value_i,
  input logic [6:0]  cursor_col_i,
  input logic [4:0]  cursor_row_i,
  input logic        scrolled_i
);

  `TCCS_ASSERT(a_out_hold, clk_i, rst_ni,
               out_valid_i && out_stall_i |=> out_valid_i && $stable(cell_value_i) &&
               $stable(cursor_col_i) && $stable(cursor_row_i) && $stable(scrolled_i),
               "Stalled result changed")
  `TCCS_ASSERT(a_one_per_two, clk_i, rst_ni,
               in_valid_i && !in_stall_i |=> in_stall_i,
               "Requests taken in adjacent cycles")
  `TCCS_ASSERT(a_scroll_row, clk_i, rst_ni,
               out_valid_i && scrolled_i |->
               (cursor_row_i == 5'(ROWS - 1)) && (cell_value_i == 16'h0000),
               "Scroll result off the last row")
  `TCCS_ASSERT_NEVER(a_cursor_range, clk_i, rst_ni,
                     out_valid_i && ((32'(cursor_col_i) >= COLUMNS) ||
                     (32'(cursor_row_i) >= ROWS)),
                     "Cursor outside the screen")

endmodule

bind text_console_cursor_scroll tccs_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tccs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_i   (in_stall_o),
  .out_valid_i  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .cell_value_i (cell_value_o),
  .cursor_col_i (cursor_col_o),
  .cursor_row_i (cursor_row_o),
  .scrolled_i   (scrolled_o)
);

// ===== sim/tb.sv =====
// Self-checking testbench for the text console: drives requests, keeps its own
// copy of the screen, cursor and attribute, and checks every result in order.
// Depends on tccs_pkg and text_console_cursor_scroll.
module tb;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;

  // The package names only the three used modes; the fourth is a no-op.
  localparam logic [1:0]       MODE_UNUSED = 2'd3;
  localparam tccs_pkg::byte_t  CHAR_NUL    = 8'h00;

  typedef struct packed {
    tccs_pkg::cell_t     value;
    tccs_pkg::col_port_t col;
    tccs_pkg::row_port_t row;
    logic                scrolled;
  } console_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [7:0]  cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  mode_i;
  logic [7:0]  char_code_i;
  logic [10:0] cell_index_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [15:0] cell_value_o;
  logic [6:0]  cursor_col_o;
  logic [4:0]  cursor_row_o;
  logic        scrolled_o;

  text_console_cursor_scroll #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .char_code_i (char_code_i),
    .cell_index_i(cell_index_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cell_value_o(cell_value_o),
    .cursor_col_o(cursor_col_o),
    .cursor_row_o(cursor_row_o),
    .scrolled_o  (scrolled_o)
  );

  // Shadow copy of the console: screen contents, cursor and attribute.
  tccs_pkg::cell_t screen_cells [CELL_COUNT];
  int              cur_col;
  int              cur_row;
  tccs_pkg::byte_t text_attr;

  // Results owed by the block, oldest first.
  console_result_t pending_results[$];
  int              mismatches = 0;

  // Set by a test to make the receiver hold off for that many cycles.
  int hold_off_cycles = 0;

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // ---------------------------------------------------------------------------
  // Screen model
  // ---------------------------------------------------------------------------

  function automatic void blank_screen();
    for (int i = 0; i < CELL_COUNT; i++) begin
      screen_cells[i] = tccs_pkg::BLANK_CELL;
    end
  endfunction

  // Applies one accepted request to the shadow console and returns the result
  // that the block must produce for it.
  function automatic console_result_t apply_request(input logic [1:0] m,
                                                    input tccs_pkg::byte_t code,
                                                    input tccs_pkg::index_port_t idx);
    console_result_t res;
    res = '0;
    case (m)
      tccs_pkg::MODE_PUT: begin
        if (code == tccs_pkg::CHAR_NEWLINE) begin
          cur_col = 0;
          cur_row++;
        end else if (code == tccs_pkg::CHAR_BACKSPACE) begin
          // Backspace never erases and stops at the left edge.
          if (cur_col != 0) begin
            cur_col--;
          end
        end else begin
          screen_cells[cur_row * COLUMNS + cur_col] = {text_attr, code};
          cur_col++;
          if (cur_col >= COLUMNS) begin
            cur_col = 0;
            cur_row++;
          end
        end
        // Leaving the bottom row moves the whole screen up by one row.
        if (cur_row >= ROWS) begin
          for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) begin
            screen_cells[i] = screen_cells[i + COLUMNS];
          end
          for (int i = (ROWS - 1) * COLUMNS; i < CELL_COUNT; i++) begin
            screen_cells[i] = tccs_pkg::BLANK_CELL;
          end
          cur_row      = ROWS - 1;
          res.scrolled = 1'b1;
        end
      end
      tccs_pkg::MODE_CLEAR: begin
        blank_screen();
        cur_col = 0;
        cur_row = 0;
      end
      tccs_pkg::MODE_READ: begin
        // Reads past the last cell return zero.
        if (idx < CELL_COUNT) begin
          res.value = screen_cells[idx];
        end
      end
      default: begin
      end
    endcase
    res.col = tccs_pkg::col_port_t'(cur_col);
    res.row = tccs_pkg::row_port_t'(cur_row);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Mostly back-to-back or short gaps, with the occasional long pause.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 40);
  endfunction

  // Offers one request and returns at the edge where it is taken. Valid is
  // left high so that the next request can follow without a bubble.
  task automatic send_request(input logic [1:0] m, input tccs_pkg::byte_t code,
                              input tccs_pkg::index_port_t idx,
                              input bit no_gap = 1'b0);
    int gap;
    gap = no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    mode_i       <= m;
    char_code_i  <= code;
    cell_index_i <= idx;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    pending_results.push_back(apply_request(m, code, idx));
  endtask

  // Drops valid and waits until every owed result has come back.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_attribute(input tccs_pkg::byte_t attr);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= attr;
    @(posedge clk_i);
    text_attr = attr;
    cfg_we_i  <= 1'b0;
  endtask

  function automatic tccs_pkg::byte_t printable_char();
    return tccs_pkg::byte_t'($urandom_range(8'h20, 8'h7E));
  endfunction

  // Index of a cell on the row the cursor is on, where recent text sits.
  function automatic tccs_pkg::index_port_t cursor_row_cell();
    return tccs_pkg::index_port_t'(cur_row * COLUMNS + $urandom_range(0, COLUMNS - 1));
  endfunction

  // Text-like traffic: mostly characters with line breaks at the given rate,
  // reads of recent and random cells, and now and then a clear, an unused mode
  // or a read past the end of the screen.
  task automatic run_random_text(input int count, input int newline_pct);
    int              r;
    int              p;
    tccs_pkg::byte_t code;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 999);
      if (r < 3) begin
        send_request(tccs_pkg::MODE_CLEAR, tccs_pkg::byte_t'($urandom),
                     tccs_pkg::index_port_t'($urandom));
      end else if (r < 18) begin
        send_request(MODE_UNUSED, tccs_pkg::byte_t'($urandom),
                     tccs_pkg::index_port_t'($urandom));
      end else if (r < 240) begin
        p = $urandom_range(0, 9);
        if (p < 6) begin
          send_request(tccs_pkg::MODE_READ, tccs_pkg::byte_t'($urandom),
                       cursor_row_cell());
        end else if (p < 9) begin
          send_request(tccs_pkg::MODE_READ, tccs_pkg::byte_t'($urandom),
                       tccs_pkg::index_port_t'($urandom_range(0, CELL_COUNT - 1)));
        end else begin
          send_request(tccs_pkg::MODE_READ, tccs_pkg::byte_t'($urandom),
                       tccs_pkg::index_port_t'($urandom_range(CELL_COUNT, 2047)));
        end
      end else begin
        p = $urandom_range(0, 99);
        if (p < newline_pct) begin
          code = tccs_pkg::CHAR_NEWLINE;
        end else if (p < newline_pct + 4) begin
          code = tccs_pkg::CHAR_BACKSPACE;
        end else if (p < newline_pct + 6) begin
          code = CHAR_NUL;
        end else begin
          code = tccs_pkg::byte_t'($urandom);
        end
        send_request(tccs_pkg::MODE_PUT, code, tccs_pkg::index_port_t'($urandom));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset contents, out-of-range reads, edge characters, backspace at the left
  // edge, the unused mode and clear, all with the reset attribute.
  task automatic test_special_cases();
    send_request(tccs_pkg::MODE_READ, 8'h00, 11'd0);
    send_request(tccs_pkg::MODE_READ, 8'hFF, 11'd1999);
    send_request(tccs_pkg::MODE_READ, 8'h00, 11'd2000);
    send_request(tccs_pkg::MODE_READ, 8'hFF, 11'd2047);
    send_request(tccs_pkg::MODE_PUT, tccs_pkg::CHAR_BACKSPACE, 11'd0);
    send_request(tccs_pkg::MODE_PUT, CHAR_NUL, 11'h7FF);
    send_request(tccs_pkg::MODE_PUT, 8'hFF, 11'd0);
    send_request(tccs_pkg::MODE_PUT, 8'h80, 11'd0);
    send_request(tccs_pkg::MODE_PUT, 8'h41, 11'd0);
    send_request(tccs_pkg::MODE_PUT, tccs_pkg::CHAR_BACKSPACE, 11'd0);
    send_request(tccs_pkg::MODE_PUT, tccs_pkg::CHAR_NEWLINE, 11'd0);
    send_request(MODE_UNUSED, 8'hFF, 11'h7FF);
    send_request(MODE_UNUSED, 8'h00, 11'd0);
    for (int i = 0; i < 4; i++) begin
      send_request(tccs_pkg::MODE_READ, 8'h00, tccs_pkg::index_port_t'(i));
    end
    send_request(tccs_pkg::MODE_CLEAR, 8'hFF, 11'h7FF);
    send_request(tccs_pkg::MODE_READ, 8'h00, 11'd0);
    send_request(tccs_pkg::MODE_READ, 8'h00, 11'd1);
  endtask

  // Walks the cursor to the bottom, scrolls once by newline and once by
  // running off the end of the last row, and reads back the moved rows.
  task automatic test_wrap_and_scroll();
    send_request(tccs_pkg::MODE_CLEAR, tccs_pkg::byte_t'($urandom),
                 tccs_pkg::index_port_t'($urandom));
    send_request(tccs_pkg::MODE_PUT, printable_char(), tccs_pkg::index_port_t'($urandom));
    send_request(tccs_pkg::MODE_PUT, tccs_pkg::CHAR_NEWLINE,
                 tccs_pkg::index_port_t'($urandom));
    send_request(tccs_pkg::MODE_PUT, printable_char(), tccs_pkg::index_port_t'($urandom));
    for (int i = 0; i < ROWS - 1; i++) begin
      send_request(tccs_pkg::MODE_PUT, tccs_pkg::CHAR_NEWLINE,
                   tccs_pkg::index_port_t'($urandom));
    end
    send_request(tccs_pkg::MODE_READ, 8'h00, 11'd0);
    send_request(tccs_pkg::MODE_READ, 8'h00, tccs_pkg::index_port_t'((ROWS - 1) * COLUMNS));
    for (int i = 0; i < COLUMNS; i++) begin
      send_request(tccs_pkg::MODE_PUT, printable_char(), tccs_pkg::index_port_t'($urandom));
    end
    send_request(tccs_pkg::MODE_READ, 8'h00, tccs_pkg::index_port_t'((ROWS - 2) * COLUMNS));
    send_request(tccs_pkg::MODE_READ, 8'h00,
                 tccs_pkg::index_port_t'((ROWS - 1) * COLUMNS - 1));
    send_request(tccs_pkg::MODE_READ, 8'h00, tccs_pkg::index_port_t'(CELL_COUNT - 1));
  endtask

  // Random text under a series of attributes, the extremes among them.
  task automatic test_attribute_settings();
    write_attribute(8'h00);
    run_random_text(400, 12);
    write_attribute(8'hFF);
    run_random_text(400, 1);
    write_attribute(tccs_pkg::byte_t'($urandom));
    run_random_text(400, 20);
    write_attribute(tccs_pkg::byte_t'($urandom));
    run_random_text(400, 6);
    write_attribute(tccs_pkg::ATTR_RESET);
    run_random_text(200, 10);
  endtask

  // The receiver holds off for a long stretch while requests keep coming back
  // to back, so the output register and the request behind it fill up and the
  // block has to stall its input.
  task automatic test_output_backpressure();
    wait_idle();
    hold_off_cycles = 400;
    for (int i = 0; i < 16; i++) begin
      if (i % 2 == 0) begin
        send_request(tccs_pkg::MODE_PUT, printable_char(),
                     tccs_pkg::index_port_t'($urandom), 1'b1);
      end else begin
        send_request(tccs_pkg::MODE_READ, 8'h00, cursor_row_cell(), 1'b1);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver pacing and result checking
  // ---------------------------------------------------------------------------

  initial begin : receiver_pacing
    int   remaining;
    int   r;
    logic level;
    remaining   = 0;
    level       = 1'b0;
    out_stall_i <= 1'b0;
    @(negedge clk_i);
    forever begin
      @(posedge clk_i);
      if (hold_off_cycles > 0) begin
        level           = 1'b1;
        remaining       = hold_off_cycles;
        hold_off_cycles = 0;
      end else if (remaining == 0) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          level     = 1'b0;
          remaining = $urandom_range(50, 150);
        end else if (r < 55) begin
          level     = 1'b0;
          remaining = $urandom_range(1, 24);
        end else if (r < 88) begin
          level     = 1'b1;
          remaining = $urandom_range(1, 3);
        end else if (r < 97) begin
          level     = 1'b1;
          remaining = $urandom_range(4, 15);
        end else begin
          level     = 1'b1;
          remaining = $urandom_range(30, 60);
        end
      end
      out_stall_i <= level;
      remaining--;
    end
  end

  always @(posedge clk_i) begin : result_check
    console_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: value %h col %0d row %0d",
               cell_value_o, cursor_col_o, cursor_row_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (cell_value_o !== want.value) begin
          $error("cell_value: expected %h, got %h", want.value, cell_value_o);
          mismatches++;
        end
        if (cursor_col_o !== want.col) begin
          $error("cursor_col: expected %0d, got %0d", want.col, cursor_col_o);
          mismatches++;
        end
        if (cursor_row_o !== want.row) begin
          $error("cursor_row: expected %0d, got %0d", want.row, cursor_row_o);
          mismatches++;
        end
        if (scrolled_o !== want.scrolled) begin
          $error("scrolled: expected %b, got %b", want.scrolled, scrolled_o);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin : test_sequence
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_data_i   <= '0;
    in_valid_i   <= 1'b0;
    mode_i       <= tccs_pkg::MODE_PUT;
    char_code_i  <= '0;
    cell_index_i <= '0;
    blank_screen();
    cur_col   = 0;
    cur_row   = 0;
    text_attr = tccs_pkg::ATTR_RESET;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The block blanks its memory after reset and stalls meanwhile; the first
    // request simply waits for it.
    test_special_cases();
    test_wrap_and_scroll();
    test_output_backpressure();
    test_attribute_settings();

    wait_idle();
    // A scroll or clear is the longest the block can stay busy, so give any
    // stray result that long to show up.
    repeat (COLUMNS * ROWS + 10) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Far beyond the slowest legal run: every request a full-screen scroll with
  // the longest gaps and stalls on both sides.
  initial begin : watchdog
    #150_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/tccs_pkg.sv
design/tccs_ctrl.sv
design/tccs_dp.sv
design/text_console_cursor_scroll.sv
design/tccs_checker.sv
sim/tb.sv
